@@ hdl/lr_pkg.sv @@
// Shared types and constants for the line rasterizer.
// Used by the channel interfaces and by line_rasterizer_core; depends on nothing.
package lr_pkg;

	// Width of every pixel coordinate.
	localparam int COORD_BITS = 6;

	// One coordinate on the grid.
	typedef logic [COORD_BITS-1:0] coord_t;

	// Signed difference between two coordinates.
	typedef logic signed [COORD_BITS:0] delta_t;

	// Remainder accumulator with headroom for one add or subtract of a span.
	typedef logic signed [COORD_BITS+1:0] acc_t;

endpackage

@@ hdl/lr_seg_if.sv @@
// Segment channel: valid/ready handshake carrying two endpoints.
// Depends on lr_pkg for the coordinate type.
interface lr_seg_if;
	import lr_pkg::*;

	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);

endinterface

@@ hdl/lr_pix_if.sv @@
// Pixel channel: valid/ready handshake carrying one pixel and a last flag.
// Depends on lr_pkg for the coordinate type.
interface lr_pix_if;
	import lr_pkg::*;

	logic   valid;
	logic   ready;
	coord_t pixel_x;
	coord_t pixel_y;
	logic   last;

	modport source (output valid, pixel_x, pixel_y, last, input ready);
	modport sink   (input valid, pixel_x, pixel_y, last, output ready);

endinterface

@@ hdl/line_rasterizer_core.sv @@
// Line rasterizer top level: setup pipeline, stepping stage and output register.
// Depends on lr_pkg, lr_seg_if and lr_pix_if.
//
//   Channel  Dir  Payload                              Transfer
//   seg      in   start_x, start_y, end_x, end_y       seg.valid & seg.ready
//   pix      out  pixel_x, pixel_y, last               pix.valid & pix.ready
//
// A segment whose major span is d yields d + 1 pixels (1 to 64), one per cycle
// from the stepping stage while pix is not stalled. The first pixel passes the
// three setup stages, then the stepping stage and the output register. The next
// segment is loaded in the cycle its predecessor's last pixel leaves the
// stepping stage, so consecutive segments run with no gap.
// Reset clears all valid bits; stalls on pix hold every occupied stage in place.
module line_rasterizer_core (
	input  logic clk,
	input  logic arst_n,
	lr_seg_if.sink   seg,
	lr_pix_if.source pix
);
	import lr_pkg::*;

	// Stage 1: captured endpoints.
	logic   v_s1;
	coord_t ax_s1, ay_s1, bx_s1, by_s1;

	// Stage 2: axes arranged by steepness.
	logic   v_s2;
	logic   steep_s2;
	coord_t ma_s2, na_s2, mb_s2, nb_s2;

	// Stage 3: ordered start point, major span and minor delta.
	logic   v_s3;
	logic   steep_s3;
	coord_t m0_s3, n0_s3, d_s3;
	delta_t delta_s3;

	// Stepping stage.
	logic   it_v_q;
	logic   it_steep_q;
	coord_t it_major_q, it_minor_q, it_rem_q, it_r_q, it_d_q;
	delta_t it_delta_q;

	// Output register.
	logic   ov_q;
	coord_t px_q, py_q;
	logic   last_q;

	// Flow control, from the output back to the input.
	logic out_en, emit, it_done, it_take, s3_adv, s3_en, s2_en, s1_en;

	assign out_en  = !ov_q || pix.ready;
	assign emit    = it_v_q && out_en;
	assign it_done = emit && (it_rem_q == '0);
	assign it_take = !it_v_q || it_done;
	assign s3_adv  = v_s3 && it_take;
	assign s3_en   = !v_s3 || it_take;
	assign s2_en   = !v_s2 || s3_en;
	assign s1_en   = !v_s1 || s2_en;
	assign seg.ready = s1_en;

	// Spans and steepness from the captured endpoints.
	coord_t span_x, span_y;
	logic   steep_c;

	always_comb begin
		span_x  = (ax_s1 > bx_s1) ? coord_t'(ax_s1 - bx_s1) : coord_t'(bx_s1 - ax_s1);
		span_y  = (ay_s1 > by_s1) ? coord_t'(ay_s1 - by_s1) : coord_t'(by_s1 - ay_s1);
		steep_c = span_x < span_y;
	end

	// Order the endpoints so the major coordinate increases.
	coord_t m0_c, n0_c, m1_c, n1_c, d_c;
	delta_t delta_c;

	always_comb begin
		if (ma_s2 > mb_s2) begin
			m0_c = mb_s2;
			n0_c = nb_s2;
			m1_c = ma_s2;
			n1_c = na_s2;
		end else begin
			m0_c = ma_s2;
			n0_c = na_s2;
			m1_c = mb_s2;
			n1_c = nb_s2;
		end
		d_c     = coord_t'(m1_c - m0_c);
		delta_c = delta_t'($signed({1'b0, n1_c}) - $signed({1'b0, n0_c}));
	end

	// One step of the minor coordinate: keep delta*k = q*d + r with 0 <= r < d.
	acc_t   acc, acc_d;
	acc_t   acc_adj;
	coord_t minor_n;

	always_comb begin
		acc     = $signed({2'b00, it_r_q}) + $signed({it_delta_q[COORD_BITS], it_delta_q});
		acc_d   = $signed({2'b00, it_d_q});
		acc_adj = acc;
		minor_n = it_minor_q;
		if (!it_delta_q[COORD_BITS]) begin
			if (acc >= acc_d) begin
				acc_adj = acc - acc_d;
				minor_n = coord_t'(it_minor_q + 1'b1);
			end
		end else begin
			if (acc < 0) begin
				acc_adj = acc + acc_d;
				minor_n = coord_t'(it_minor_q - 1'b1);
			end
		end
	end

	// Valid bits of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			it_v_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (s1_en) v_s1 <= seg.valid;
			if (s2_en) v_s2 <= v_s1;
			if (s3_en) v_s3 <= v_s2;
			if (it_take) it_v_q <= v_s3;
			if (out_en) ov_q <= it_v_q;
		end
	end

	// Setup pipeline payload.
	always_ff @(posedge clk) begin
		if (s1_en && seg.valid) begin
			ax_s1 <= seg.start_x;
			ay_s1 <= seg.start_y;
			bx_s1 <= seg.end_x;
			by_s1 <= seg.end_y;
		end
		if (s2_en && v_s1) begin
			steep_s2 <= steep_c;
			ma_s2    <= steep_c ? ay_s1 : ax_s1;
			na_s2    <= steep_c ? ax_s1 : ay_s1;
			mb_s2    <= steep_c ? by_s1 : bx_s1;
			nb_s2    <= steep_c ? bx_s1 : by_s1;
		end
		if (s3_en && v_s2) begin
			steep_s3 <= steep_s2;
			m0_s3    <= m0_c;
			n0_s3    <= n0_c;
			d_s3     <= d_c;
			delta_s3 <= delta_c;
		end
	end

	// Stepping stage: load a new segment or advance one major step.
	always_ff @(posedge clk) begin
		if (s3_adv) begin
			it_steep_q <= steep_s3;
			it_major_q <= m0_s3;
			it_minor_q <= n0_s3;
			it_rem_q   <= d_s3;
			it_r_q     <= '0;
			it_d_q     <= d_s3;
			it_delta_q <= delta_s3;
		end else if (emit) begin
			it_major_q <= coord_t'(it_major_q + 1'b1);
			it_minor_q <= minor_n;
			it_rem_q   <= coord_t'(it_rem_q - 1'b1);
			it_r_q     <= acc_adj[COORD_BITS-1:0];
		end
	end

	// Output register: swap the axes back for steep lines.
	always_ff @(posedge clk) begin
		if (emit) begin
			px_q   <= it_steep_q ? it_minor_q : it_major_q;
			py_q   <= it_steep_q ? it_major_q : it_minor_q;
			last_q <= (it_rem_q == '0);
		end
	end

	assign pix.valid   = ov_q;
	assign pix.pixel_x = px_q;
	assign pix.pixel_y = py_q;
	assign pix.last    = last_q;

	// The remainder stays below the span while a segment is being stepped.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(it_v_q && it_d_q != '0) |-> (it_r_q < it_d_q))
		else $error("stepping remainder out of range");

	// A stalled stepping stage keeps its position.
	a_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(it_v_q && !emit) |=> (it_v_q && $stable(it_rem_q) && $stable(it_major_q)))
		else $error("stepping stage moved while stalled");

	// The last flag follows the step count of the emitted pixel.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (pix.valid && pix.last == $past(it_rem_q == '0)))
		else $error("last flag does not match step count");

	// A new segment is only loaded when the previous one is finished.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(s3_adv && it_v_q) |-> it_done)
		else $error("segment loaded over an unfinished one");

endmodule
